// ===== rtl/cpg_pkg.sv =====
// shared types and constants for the curve point generator
`timescale 1ns / 1ps
package cpg_pkg;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ANGLE_W = 24;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  typedef enum logic [2:0] {
    REG_MODE = 3'd0,
    REG_COUNT = 3'd1,
    REG_RADIUS = 3'd2,
    REG_COMPLETE = 3'd3,
    REG_GAINS = 3'd4,
    REG_START = 3'd5,
    REG_CONTROL = 3'd6,
    REG_END = 3'd7
  } reg_index_t;

  function automatic logic signed [24:0] atan_step(input logic [3:0] k);
    case (k)
      4'd0: atan_step = 25'sd2097152;
      4'd1: atan_step = 25'sd1238021;
      4'd2: atan_step = 25'sd654136;
      4'd3: atan_step = 25'sd332050;
      4'd4: atan_step = 25'sd166669;
      4'd5: atan_step = 25'sd83416;
      4'd6: atan_step = 25'sd41718;
      4'd7: atan_step = 25'sd20860;
      4'd8: atan_step = 25'sd10430;
      4'd9: atan_step = 25'sd5215;
      4'd10: atan_step = 25'sd2608;
      4'd11: atan_step = 25'sd1304;
      4'd12: atan_step = 25'sd652;
      4'd13: atan_step = 25'sd326;
      4'd14: atan_step = 25'sd163;
      4'd15: atan_step = 25'sd81;
      default: atan_step = 25'sd0;
    endcase
  endfunction
endpackage

// ===== rtl/cpg_divider.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module cpg_divider #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DEN_W = 9,
  parameter int unsigned TAG_W = 8
) (
  input  logic             clk,
  input  logic             advance,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic [NUM_W-1:0] quot,
  output logic [TAG_W-1:0] tag_out
);
  logic [NUM_W-1:0] q   [NUM_W+1];
  logic [DEN_W-1:0] rem [NUM_W+1];
  logic [DEN_W-1:0] d   [NUM_W+1];
  logic [TAG_W-1:0] tg  [NUM_W+1];

  assign q[0] = num;
  assign rem[0] = '0;
  assign d[0] = den;
  assign tg[0] = tag_in;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           fits;
    assign trial = {rem[s], q[s][NUM_W-1]};
    assign fits = trial >= {1'b0, d[s]};
    always_ff @(posedge clk) begin
      if (advance) begin
        rem[s+1] <= fits ? DEN_W'(trial - {1'b0, d[s]}) : trial[DEN_W-1:0];
        q[s+1] <= {q[s][NUM_W-2:0], fits};
        d[s+1] <= d[s];
        tg[s+1] <= tg[s];
      end
    end
  end

  assign quot = q[NUM_W];
  assign tag_out = tg[NUM_W];
endmodule

// ===== rtl/cpg_cordic.sv =====
// pipelined rotation cordic, one micro-rotation per stage
`timescale 1ns / 1ps
module cpg_cordic #(
  parameter int unsigned TAG_W = 8
) (
  input  logic                 clk,
  input  logic                 advance,
  input  logic [23:0]          angle,
  input  logic [TAG_W-1:0]     tag_in,
  output logic signed [33:0]   sin_q30,
  output logic signed [33:0]   cos_q30,
  output logic [TAG_W-1:0]     tag_out
);
  localparam int unsigned N = cpg_pkg::CORDIC_STEPS;
  logic signed [33:0] x [N+1];
  logic signed [33:0] y [N+1];
  logic signed [25:0] z [N+1];
  logic               ng [N+1];
  logic [TAG_W-1:0]   tg [N+1];
  logic               fold;
  logic [23:0]        a;

  assign fold = (angle[23:22] == 2'd1) || (angle[23:22] == 2'd2);
  assign a = fold ? angle - 24'h800000 : angle;
  assign x[0] = 34'(cpg_pkg::CORDIC_GAIN);
  assign y[0] = '0;
  assign z[0] = 26'(signed'(a));
  assign ng[0] = fold;
  assign tg[0] = tag_in;

  for (genvar k = 0; k < N; k++) begin : g_rot
    logic signed [33:0] xs, ys;
    logic signed [25:0] at;
    assign xs = x[k] >>> k;
    assign ys = y[k] >>> k;
    assign at = 26'(cpg_pkg::atan_step(4'(k)));
    always_ff @(posedge clk) begin
      if (advance) begin
        if (!z[k][25]) begin
          x[k+1] <= x[k] - ys;
          y[k+1] <= y[k] + xs;
          z[k+1] <= z[k] - at;
        end else begin
          x[k+1] <= x[k] + ys;
          y[k+1] <= y[k] - xs;
          z[k+1] <= z[k] + at;
        end
        ng[k+1] <= ng[k];
        tg[k+1] <= tg[k];
      end
    end
  end

  assign sin_q30 = ng[N] ? -y[N] : y[N];
  assign cos_q30 = ng[N] ? -x[N] : x[N];
  assign tag_out = tg[N];
endmodule

// ===== rtl/curve_point_generator_unit.sv =====
// top level: curve point generator pipeline
// pipeline stages from input transfer to result valid: 34 divide, 1 angle,
//   16 rotations, 3 product stages, 1 output
// throughput: one point per cycle; the whole pipeline freezes while a result stalls
// reset: clears valid bits and loads configuration reset values
`timescale 1ns / 1ps
module curve_point_generator_unit #(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned MAX_CURVE_SEGMENTS = 128,
  parameter int unsigned COORD_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    point_index,
  input  logic [15:0]                   anim_phase,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y,
  output logic signed [COORD_WIDTH-1:0] point_z,
  output logic                          index_valid,
  output logic                          last_point,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [59:0]                   cfg_data
);
  localparam int unsigned NW = 34;
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1) > $clog2(MAX_CURVE_SEGMENTS + 1) ?
                               $clog2(MAX_SEGMENTS + 1) : $clog2(MAX_CURVE_SEGMENTS + 1);
  localparam int unsigned DL = NW + 1 + cpg_pkg::CORDIC_STEPS + 4;
  localparam int unsigned LAT = DL;

  logic        mode;
  logic [8:0]  seg_count;
  logic [18:0] radius;
  logic [16:0] complete;
  logic [55:0] gains;
  logic [59:0] p_start, p_ctrl, p_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      seg_count <= 9'd64;
      radius <= 19'd8000;
      complete <= 17'd32768;
      gains <= 56'd274877907968;
      p_start <= '0;
      p_ctrl <= '0;
      p_end <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cpg_pkg::REG_MODE: mode <= cfg_data[0];
        cpg_pkg::REG_COUNT: seg_count <= cfg_data[8:0];
        cpg_pkg::REG_RADIUS: radius <= cfg_data[18:0];
        cpg_pkg::REG_COMPLETE: complete <= cfg_data[16:0];
        cpg_pkg::REG_GAINS: gains <= cfg_data[55:0];
        cpg_pkg::REG_START: p_start <= cfg_data;
        cpg_pkg::REG_CONTROL: p_ctrl <= cfg_data;
        cpg_pkg::REG_END: p_end <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic advance;
  logic [LAT-1:0] vld;
  assign advance = !out_valid || out_ready;
  assign in_ready = advance;
  assign out_valid = vld[LAT-1];
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (advance) vld <= {vld[LAT-2:0], in_valid};
  end

  // effective count and divider operands
  logic [CW-1:0] cap, n_eff;
  logic [16:0]   c_sat, arc;
  logic [31:0]   off;
  logic [NW-1:0] prod_c, num;
  assign cap = mode ? CW'(MAX_CURVE_SEGMENTS) : CW'(MAX_SEGMENTS);
  always_comb begin
    n_eff = CW'(seg_count);
    if (seg_count == 9'd0) n_eff = CW'(1);
    if ({{(CW > 9 ? CW-9 : 0){1'b0}}, seg_count} > (CW > 9 ? CW : 9)'(cap)) n_eff = cap;
  end
  assign c_sat = complete > 17'd65536 ? 17'd65536 : complete;
  assign arc = c_sat >= 17'd32768 ? 17'd65536 - c_sat : c_sat;
  assign off = c_sat > 17'd32768 ? {15'(c_sat - 17'd32768), 17'd0} : 32'd0;
  // arc*num where num = (i<<17)+(p<<1)+65536 fits 26 bits; arc*num < 2^41
  logic [26:0] num_full;
  assign num_full = {1'b0, point_index, 17'd0} + {10'd0, anim_phase, 1'b0} + 27'd65536;
  // the circle product needs up to 41 bits; bound to NW via arc<=32768 and num<2^26
  assign prod_c = NW'({17'd0, arc} * {16'd0, num_full[25:0]} >> 8);
  assign num = mode ? NW'({point_index, anim_phase}) : prod_c;

  // tag carried through the divider
  typedef struct packed {
    logic        iv;
    logic        last;
    logic        mode;
    logic [31:0] off;
  } dtag_t;
  dtag_t dt_in, dt_out;
  logic [NW-1:0] quot;
  assign dt_in.iv = {{(CW > 8 ? CW-8 : 0){1'b0}}, point_index} < (CW > 8 ? CW : 8)'(n_eff);
  assign dt_in.last = {{(CW > 8 ? CW-8 : 0){1'b0}}, point_index} ==
                      (CW > 8 ? CW : 8)'(n_eff - CW'(1));
  assign dt_in.mode = mode;
  assign dt_in.off = off;

  cpg_divider #(.NUM_W(NW), .DEN_W(CW), .TAG_W($bits(dtag_t))) u_div (
    .clk(clk), .advance(advance), .num(num), .den(n_eff),
    .tag_in(dt_in), .quot(quot), .tag_out(dt_out)
  );

  // stage: angle / t
  dtag_t       s1_tag;
  logic [23:0] s1_ang;
  logic [16:0] s1_t;
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_tag <= dt_out;
      s1_ang <= 24'((dt_out.off + {quot[23:0], 8'd0}) >> 8);
      s1_t <= quot[16:0];
    end
  end

  typedef struct packed {
    logic        iv;
    logic        last;
    logic        mode;
    logic [16:0] t;
  } ctag_t;
  ctag_t ct_in, ct_out;
  logic signed [33:0] s30, c30;
  assign ct_in = '{iv: s1_tag.iv, last: s1_tag.last, mode: s1_tag.mode, t: s1_t};
  cpg_cordic #(.TAG_W($bits(ctag_t))) u_cordic (
    .clk(clk), .advance(advance), .angle(s1_ang), .tag_in(ct_in),
    .sin_q30(s30), .cos_q30(c30), .tag_out(ct_out)
  );

  // product stages
  logic signed [19:0] s16, c16;
  assign s16 = 20'(s30 >>> 14);
  assign c16 = 20'(c30 >>> 14);
  logic signed [13:0] dx, dy, dz, dw;
  assign dx = gains[13:0];
  assign dy = gains[27:14];
  assign dz = gains[41:28];
  assign dw = gains[55:42];

  ctag_t p1_tag, p2_tag, p3_tag;
  logic signed [39:0] p1_a, p1_b, p1_c, p1_d;
  logic signed [17:0] p1_u, p1_t;
  always_ff @(posedge clk) begin
    if (advance) begin
      p1_tag <= ct_out;
      p1_a <= 40'(c16 * $signed({1'b0, radius}));
      p1_b <= 40'(s16 * $signed({1'b0, radius}));
      p1_c <= 40'((s16 * s16) >>> 16);
      p1_d <= 40'((c16 * c16) >>> 16);
      p1_t <= 18'(ct_out.t);
      p1_u <= 18'sd65536 - 18'(ct_out.t);
    end
  end

  logic signed [55:0] p2_x, p2_z, p2_y;
  logic signed [35:0] p2_w0, p2_w1, p2_w2;
  always_ff @(posedge clk) begin
    if (advance) begin
      p2_tag <= p1_tag;
      p2_x <= 56'(p1_a * dx);
      p2_z <= 56'(p1_b * dz);
      p2_y <= 56'(p1_c * dy + p1_d * dw);
      p2_w0 <= 36'(p1_u * p1_u);
      p2_w1 <= 36'(2 * p1_u * p1_t);
      p2_w2 <= 36'(p1_t * p1_t);
    end
  end

  function automatic logic signed [19:0] pt(input logic [59:0] v, input int j);
    pt = v[20*j +: 20];
  endfunction

  logic signed [63:0] p3_x, p3_y, p3_z;
  logic signed [63:0] b0 [3];
  always_comb begin
    for (int j = 0; j < 3; j++)
      b0[j] = 64'(p2_w0 * pt(p_start, j)) + 64'(p2_w1 * pt(p_ctrl, j)) +
              64'(p2_w2 * pt(p_end, j));
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      p3_tag <= p2_tag;
      if (p2_tag.mode) begin
        p3_x <= (b0[0] + 64'sd2147483648) >>> 32;
        p3_y <= (b0[1] + 64'sd2147483648) >>> 32;
        p3_z <= (b0[2] + 64'sd2147483648) >>> 32;
      end else begin
        p3_x <= (64'(p2_x) + 64'sd33554432) >>> 26;
        p3_z <= (64'(p2_z) + 64'sd33554432) >>> 26;
        p3_y <= (64'(p2_y) * $signed({1'b0, radius}) + 64'sd33554432) >>> 26;
      end
    end
  end

  function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [63:0] v);
    if (v > 64'((64'sd1 <<< (COORD_WIDTH - 1)) - 1))
      sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    else if (v < -(64'sd1 <<< (COORD_WIDTH - 1)))
      sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    else
      sat = v[COORD_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (advance) begin
      index_valid <= p3_tag.iv;
      last_point <= p3_tag.iv && p3_tag.last;
      point_x <= p3_tag.iv ? sat(p3_x) : '0;
      point_y <= p3_tag.iv ? sat(p3_y) : '0;
      point_z <= p3_tag.iv ? sat(p3_z) : '0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst) out_valid && last_point |-> index_valid)
    else $error("last point without valid index");
  assert property (@(posedge clk) disable iff (rst) out_valid && !index_valid |->
                   point_x == '0 && point_y == '0 && point_z == '0)
    else $error("invalid index gives nonzero point");
endmodule
